FILE: hdl/saq_pkg.sv
// Shared types and constants for the sorted alarm queue.
package saq_pkg;
  localparam int unsigned SecBits  = 32;
  localparam int unsigned MsBits   = 10;
  localparam int unsigned PresBits = 15;
  localparam int unsigned StatBits = 3;
  localparam int unsigned OutIdBits = 16;
  localparam int unsigned OutHdlBits = 8;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_FIRE   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_PAST      = 3'd1,
    ST_FULL      = 3'd2,
    ST_CANCELLED = 3'd3,
    ST_IGNORED   = 3'd4,
    ST_FIRED     = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  // Operation broadcast to every cell for one cycle.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_OUT  = 2'd1,
    S_FIRE = 2'd2
  } state_t;

  // True if time a is at or before time b.
  function automatic logic not_later(input logic [SecBits-1:0] as_v,
                                     input logic [MsBits-1:0] ams,
                                     input logic [SecBits-1:0] bs_v,
                                     input logic [MsBits-1:0] bms);
    not_later = (as_v == bs_v) ? (ams <= bms) : (as_v < bs_v);
  endfunction
endpackage

FILE: hdl/saq_if.sv
// Valid/ready channel carrying a payload of a given type.
interface saq_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/sorted_alarm_queue.sv
// Top level of the sorted alarm queue: command control and the row of cells.
//
// From transfer to result a command passes the request register, which also
// captures the request time in milliseconds, and the result register, written
// as the request is evaluated against the row of slot cells (all cells compare
// in parallel and shift together). A fire that pops k entries yields k
// results, one per cycle as the consumer takes them. A new command is taken
// once the last result of the previous one has been transferred.
module sorted_alarm_queue #(
  parameter int unsigned QUEUE_DEPTH = 10,
  parameter int unsigned ID_BITS = 16,
  parameter int unsigned HANDLE_BITS = 8
) (
  input logic clk,
  input logic rst,
  saq_if.sink   in_ch,
  saq_if.source out_ch
);
  import saq_pkg::*;

  localparam int unsigned D = QUEUE_DEPTH;

  state_t state, state_next;

  // registered request
  logic               busy;
  cmd_t               r_cmd;
  logic [SecBits-1:0] r_asec;
  logic [MsBits-1:0]  r_ams;
  logic [HANDLE_BITS-1:0] r_hdl;
  logic [ID_BITS-1:0] r_cid;
  logic [SecBits-1:0] r_nsec;
  logic [MsBits-1:0]  r_nms;
  logic [ID_BITS-1:0] next_id;
  logic [SecBits-1:0] fire_sec;

  // result register
  logic [StatBits-1:0] o_stat;
  logic [OutIdBits-1:0] o_id;
  logic [OutHdlBits-1:0] o_hdl;
  logic [SecBits-1:0] o_esec;
  logic o_last;

  // cell row
  op_t op;
  logic [SecBits-1:0] ins_sec;
  logic [D:0] c_valid, c_ins, c_hit;
  logic [SecBits-1:0] c_sec [D+1];
  logic [MsBits-1:0] c_ms [D+1];
  logic [ID_BITS-1:0] c_id [D+1];
  logic [HANDLE_BITS-1:0] c_hdl [D+1];
  logic kill_en;
  logic [ID_BITS-1:0] kill_id;

  // request ms from prescaler: pres*1000 >> 15
  logic [PresBits+MsBits-1:0] ms_prod;
  assign ms_prod = (PresBits+MsBits)'(in_ch.data.now_prescaler) * (PresBits+MsBits)'(1000);

  assign in_ch.ready = (state == S_IDLE) && !busy;
  logic in_xfer, out_xfer;
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;

  // pop the next entry of a fire group as the current result is transferred
  logic pop_more;
  assign pop_more = (state == S_OUT || state == S_FIRE) && out_xfer && !o_last;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      r_cmd  <= cmd_t'(in_ch.data.command);
      r_asec <= in_ch.data.alarm_seconds;
      r_ams  <= in_ch.data.alarm_ms;
      r_hdl  <= HANDLE_BITS'(in_ch.data.callback_handle);
      r_cid  <= ID_BITS'(in_ch.data.cancel_id);
      r_nsec <= in_ch.data.now_seconds;
      r_nms  <= ms_prod[PresBits+MsBits-1:PresBits];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) busy <= 1'b0;
    else if (in_xfer) busy <= (cmd_t'(in_ch.data.command) != CMD_NONE);
    else busy <= 1'b0;
  end

  // evaluation of the registered request
  logic past, bump, full, any_hit, id_zero;
  logic [ID_BITS-1:0] id_inc;
  assign past = not_later(r_asec, r_ams, r_nsec, r_nms);
  assign bump = not_later(r_asec, r_ams, r_nsec + SecBits'(1), r_nms);
  assign ins_sec = bump ? r_asec + SecBits'(1) : r_asec;
  assign full = c_valid[D];
  assign id_inc = next_id + ID_BITS'(1);
  assign id_zero = (r_cid == '0);
  assign any_hit = c_hit[D];

  always_comb begin
    kill_en = 1'b0;
    kill_id = r_cid;
    op = OP_HOLD;
    if (busy) begin
      case (r_cmd)
        CMD_ADD: if (!past && !full) op = OP_INSERT;
        CMD_CANCEL: begin
          kill_en = !id_zero;
          if (!id_zero && any_hit) op = OP_REMOVE;
        end
        CMD_FIRE: begin
          kill_en = 1'b1;
          kill_id = c_id[1];
          if (c_valid[1]) op = OP_REMOVE;
        end
        default: ;
      endcase
    end else if (pop_more) begin
      kill_en = 1'b1;
      kill_id = c_id[1];
      op = OP_REMOVE;
    end
  end

  // hit chain in fire mode targets the head only
  assign c_valid[0] = 1'b1;
  assign c_ins[0] = 1'b0;
  assign c_hit[0] = 1'b0;
  assign c_sec[0] = ins_sec;
  assign c_ms[0] = r_ams;
  assign c_id[0] = id_inc;
  assign c_hdl[0] = r_hdl;

  logic fire_mode;
  assign fire_mode = (busy && r_cmd == CMD_FIRE) || pop_more;

  for (genvar g = 1; g <= D; g++) begin : g_cell
    logic r_valid;
    logic [SecBits-1:0] r_sec;
    logic [MsBits-1:0] r_ms;
    logic [ID_BITS-1:0] r_id;
    logic [HANDLE_BITS-1:0] r_h;
    logic hit_raw;
    if (g < D) begin : g_mid
      assign r_valid = c_valid[g+1];
      assign r_sec = c_sec[g+1];
      assign r_ms = c_ms[g+1];
      assign r_id = c_id[g+1];
      assign r_h = c_hdl[g+1];
    end else begin : g_end
      assign r_valid = 1'b0;
      assign r_sec = '0;
      assign r_ms = '0;
      assign r_id = '0;
      assign r_h = '0;
    end
    saq_cell #(.ID_BITS(ID_BITS), .HANDLE_BITS(HANDLE_BITS)) u_cell (
      .clk, .rst, .op,
      .new_sec(ins_sec), .new_ms(r_ams), .new_id(id_inc), .new_hdl(r_hdl),
      .kill_id, .kill_en(kill_en && (!fire_mode || g == 1)),
      .left_valid(c_valid[g-1] && (g == 1 ? 1'b1 : 1'b1)),
      .left_ins(c_ins[g-1]), .left_hit(c_hit[g-1]),
      .left_sec(c_sec[g-1]), .left_ms(c_ms[g-1]),
      .left_id(c_id[g-1]), .left_hdl(c_hdl[g-1]),
      .right_valid(r_valid), .right_sec(r_sec), .right_ms(r_ms),
      .right_id(r_id), .right_hdl(r_h),
      .valid(c_valid[g]), .ins(c_ins[g]), .hit(hit_raw),
      .sec(c_sec[g]), .ms(c_ms[g]), .id(c_id[g]), .hdl(c_hdl[g])
    );
    assign c_hit[g] = hit_raw;
  end

  // first cell always becomes valid on insert, since slot 0 is the left end
  // (c_valid[0] tied high), later cells follow their left neighbour.

  // seconds of the matched cell for cancel: the cell where the hit chain first goes high
  logic [SecBits-1:0] hit_sec;
  always_comb begin
    hit_sec = '0;
    for (int i = D; i >= 1; i--) begin
      if (c_hit[i] && !c_hit[i-1]) hit_sec = c_sec[i];
    end
  end

  // fire continues while the next entry shares the popped seconds
  logic more;
  assign more = c_valid[2 < D+1 ? 2 : D] && (D >= 2) && (c_sec[2 < D+1 ? 2 : D] == fire_sec);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      next_id <= '0;
    end else begin
      state <= state_next;
      if (busy && r_cmd == CMD_ADD && !past && !full) next_id <= id_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      case (r_cmd)
        CMD_ADD: begin
          o_hdl <= '0;
          o_last <= 1'b1;
          if (past) begin
            o_stat <= ST_PAST; o_id <= '0; o_esec <= '0;
          end else if (full) begin
            o_stat <= ST_FULL; o_id <= '0; o_esec <= '0;
          end else begin
            o_stat <= ST_ADDED;
            o_id <= OutIdBits'(id_inc);
            o_esec <= ins_sec;
          end
        end
        CMD_CANCEL: begin
          o_hdl <= '0;
          o_last <= 1'b1;
          if (!id_zero && any_hit) begin
            o_stat <= ST_CANCELLED;
            o_id <= OutIdBits'(r_cid);
            o_esec <= hit_sec;
          end else begin
            o_stat <= ST_IGNORED; o_id <= '0; o_esec <= '0;
          end
        end
        CMD_FIRE: begin
          if (c_valid[1]) begin
            o_stat <= ST_FIRED;
            o_id <= OutIdBits'(c_id[1]);
            o_hdl <= OutHdlBits'(c_hdl[1]);
            o_esec <= c_sec[1];
            o_last <= !(c_valid[2 < D+1 ? 2 : D] && c_sec[2 < D+1 ? 2 : D] == c_sec[1]);
            fire_sec <= c_sec[1];
          end else begin
            o_stat <= ST_EMPTY; o_id <= '0; o_hdl <= '0; o_esec <= '0; o_last <= 1'b1;
          end
        end
        default: begin
          o_stat <= ST_IGNORED; o_id <= '0; o_hdl <= '0; o_esec <= '0; o_last <= 1'b1;
        end
      endcase
    end else if (pop_more) begin
      o_stat <= ST_FIRED;
      o_id <= OutIdBits'(c_id[1]);
      o_hdl <= OutHdlBits'(c_hdl[1]);
      o_esec <= c_sec[1];
      o_last <= !more;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (busy) state_next = S_OUT;
      S_OUT: begin
        if (out_xfer) state_next = o_last ? S_IDLE : S_FIRE;
      end
      S_FIRE: if (out_xfer) state_next = o_last ? S_IDLE : S_FIRE;
      default: state_next = S_IDLE;
    endcase
  end

  // hold the result until it is transferred; the head fields follow the cells
  assign out_ch.valid = (state == S_OUT) || (state == S_FIRE);
  assign out_ch.data.status = status_t'(o_stat);
  assign out_ch.data.alarm_id = o_id;
  assign out_ch.data.fired_handle = o_hdl;
  assign out_ch.data.entry_seconds = o_esec;
  assign out_ch.data.head_valid = c_valid[1];
  assign out_ch.data.head_seconds = c_valid[1] ? c_sec[1] : '0;
  assign out_ch.data.head_ms = c_valid[1] ? c_ms[1] : '0;
  assign out_ch.data.last = o_last;

  a_noaccept_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    c_valid[2 < D+1 ? 2 : D] |-> c_valid[1]) else $error("queue not a prefix");
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    out_xfer && o_last |=> state == S_IDLE) else $error("stuck after last");
endmodule

FILE: hdl/saq_cell.sv
// One queue slot: holds an entry and shifts with its neighbours.
module saq_cell #(
  parameter int unsigned ID_BITS = 16,
  parameter int unsigned HANDLE_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  input  saq_pkg::op_t op,
  input  logic [saq_pkg::SecBits-1:0] new_sec,
  input  logic [saq_pkg::MsBits-1:0] new_ms,
  input  logic [ID_BITS-1:0] new_id,
  input  logic [HANDLE_BITS-1:0] new_hdl,
  input  logic [ID_BITS-1:0] kill_id,
  input  logic kill_en,
  // left neighbour
  input  logic left_valid,
  input  logic left_ins,
  input  logic left_hit,
  input  logic [saq_pkg::SecBits-1:0] left_sec,
  input  logic [saq_pkg::MsBits-1:0] left_ms,
  input  logic [ID_BITS-1:0] left_id,
  input  logic [HANDLE_BITS-1:0] left_hdl,
  // right neighbour
  input  logic right_valid,
  input  logic [saq_pkg::SecBits-1:0] right_sec,
  input  logic [saq_pkg::MsBits-1:0] right_ms,
  input  logic [ID_BITS-1:0] right_id,
  input  logic [HANDLE_BITS-1:0] right_hdl,
  output logic valid,
  output logic ins,
  output logic hit,
  output logic [saq_pkg::SecBits-1:0] sec,
  output logic [saq_pkg::MsBits-1:0] ms,
  output logic [ID_BITS-1:0] id,
  output logic [HANDLE_BITS-1:0] hdl
);
  import saq_pkg::*;

  // ins: new entry belongs here or further left; hit: matched id here or left
  always_comb begin
    ins = left_ins | ~valid | not_later(new_sec, new_ms, sec, ms);
    hit = left_hit | (kill_en & valid & (id == kill_id));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (op)
        OP_INSERT: begin
          if (left_valid) valid <= 1'b1;
        end
        OP_REMOVE: begin
          if (hit) valid <= right_valid;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_INSERT: begin
        if (left_ins) begin
          sec <= left_sec; ms <= left_ms; id <= left_id; hdl <= left_hdl;
        end else if (ins) begin
          sec <= new_sec; ms <= new_ms; id <= new_id; hdl <= new_hdl;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          sec <= right_sec; ms <= right_ms; id <= right_id; hdl <= right_hdl;
        end
      end
      default: ;
    endcase
  end
endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted alarm queue: random traffic with an in-bench predictor.
module tb_top;
  import saq_pkg::*;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] alarm_seconds;
    logic [9:0]  alarm_ms;
    logic [7:0]  callback_handle;
    logic [15:0] cancel_id;
    logic [31:0] now_seconds;
    logic [14:0] now_prescaler;
  } alarm_req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] alarm_id;
    logic [7:0]  fired_handle;
    logic [31:0] entry_seconds;
    logic        head_valid;
    logic [31:0] head_seconds;
    logic [9:0]  head_ms;
    logic        last;
  } alarm_res_t;

  typedef struct {
    logic [31:0] secs;
    logic [9:0]  ms;
    logic [15:0] id;
    logic [7:0]  hdl;
  } alarm_entry_t;

  localparam int unsigned Depth = 10;
  localparam int unsigned CycleLimit = 600000;

  logic clk;
  logic rst;
  saq_if #(.payload_t(alarm_req_t)) req_ch ();
  saq_if #(.payload_t(alarm_res_t)) res_ch ();

  sorted_alarm_queue dut (
    .clk(clk),
    .rst(rst),
    .in_ch(req_ch),
    .out_ch(res_ch)
  );

  alarm_req_t   pending_reqs[$];
  alarm_res_t   expected_res[$];
  alarm_entry_t alarm_list[$];
  logic [15:0]  last_id;
  logic [15:0]  issued_ids[$];
  int unsigned  errors;
  int unsigned  cycles;
  logic         calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic logic at_or_before(input logic [31:0] as_v, input logic [9:0] ams,
                                        input logic [31:0] bs_v, input logic [9:0] bms);
    return (as_v == bs_v) ? (ams <= bms) : (as_v < bs_v);
  endfunction

  function automatic void push_result(input status_t st, input logic [15:0] id,
                                      input logic [7:0] hdl, input logic [31:0] secs,
                                      input logic lst);
    alarm_res_t r;
    r.status = st;
    r.alarm_id = id;
    r.fired_handle = hdl;
    r.entry_seconds = secs;
    r.head_valid = alarm_list.size() != 0;
    r.head_seconds = r.head_valid ? alarm_list[0].secs : '0;
    r.head_ms = r.head_valid ? alarm_list[0].ms : '0;
    r.last = lst;
    expected_res.push_back(r);
  endfunction

  // Update the alarm list for one accepted command and queue its results.
  function automatic void predict_alarms(input alarm_req_t q);
    logic [9:0]   now_ms;
    logic [31:0]  secs;
    logic [31:0]  grp;
    int           pos;
    alarm_entry_t e;
    logic         more;
    now_ms = 10'((32'(q.now_prescaler) * 32'd1000) / 32'd32768);
    case (q.command)
      CMD_ADD: begin
        secs = q.alarm_seconds;
        if (at_or_before(secs, q.alarm_ms, q.now_seconds, now_ms)) begin
          push_result(ST_PAST, '0, '0, '0, 1'b1);
        end else begin
          if (at_or_before(secs, q.alarm_ms, q.now_seconds + 32'd1, now_ms)) secs = secs + 32'd1;
          if (alarm_list.size() >= Depth) begin
            push_result(ST_FULL, '0, '0, '0, 1'b1);
          end else begin
            last_id = last_id + 16'd1;
            e.secs = secs; e.ms = q.alarm_ms; e.id = last_id; e.hdl = q.callback_handle;
            pos = 0;
            while (pos < alarm_list.size() &&
                   !at_or_before(secs, q.alarm_ms, alarm_list[pos].secs, alarm_list[pos].ms))
              pos++;
            alarm_list.insert(pos, e);
            issued_ids.push_back(last_id);
            push_result(ST_ADDED, last_id, '0, secs, 1'b1);
          end
        end
      end
      CMD_CANCEL: begin
        pos = -1;
        if (q.cancel_id != 0)
          for (int i = 0; i < alarm_list.size(); i++)
            if (pos < 0 && alarm_list[i].id == q.cancel_id) pos = i;
        if (pos >= 0) begin
          secs = alarm_list[pos].secs;
          alarm_list.delete(pos);
          push_result(ST_CANCELLED, q.cancel_id, '0, secs, 1'b1);
        end else begin
          push_result(ST_IGNORED, '0, '0, '0, 1'b1);
        end
      end
      CMD_FIRE: begin
        if (alarm_list.size() == 0) begin
          push_result(ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          grp = alarm_list[0].secs;
          do begin
            e = alarm_list.pop_front();
            more = alarm_list.size() != 0 && alarm_list[0].secs == grp;
            push_result(ST_FIRED, e.id, e.hdl, e.secs, !more);
          end while (more);
        end
      end
      default: ;
    endcase
  endfunction

  // Driver: advance to the next pending command once the current one transfers.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) predict_alarms(req_ch.data);
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
          req_ch.data <= pending_reqs.pop_front();
          req_ch.valid <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    alarm_res_t got;
    alarm_res_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= calm || ($urandom_range(99) >= 33);
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        if (expected_res.size() == 0) begin
          report($sformatf("unexpected result status %0d", got.status));
        end else begin
          want = expected_res.pop_front();
          if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.alarm_id !== want.alarm_id)
            report($sformatf("alarm_id %0d, want %0d", got.alarm_id, want.alarm_id));
          if (got.fired_handle !== want.fired_handle)
            report($sformatf("fired_handle %0d, want %0d", got.fired_handle, want.fired_handle));
          if (got.entry_seconds !== want.entry_seconds)
            report($sformatf("entry_seconds %h, want %h", got.entry_seconds, want.entry_seconds));
          if (got.head_valid !== want.head_valid)
            report($sformatf("head_valid %b, want %b", got.head_valid, want.head_valid));
          if (got.head_seconds !== want.head_seconds)
            report($sformatf("head_seconds %h, want %h", got.head_seconds, want.head_seconds));
          if (got.head_ms !== want.head_ms)
            report($sformatf("head_ms %0d, want %0d", got.head_ms, want.head_ms));
          if (got.last !== want.last)
            report($sformatf("last %b, want %b", got.last, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    calm <= (cycles >= 3000 && cycles < 6000);
    if (cycles >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic alarm_req_t make_req(input cmd_t c, input logic [31:0] as_v,
                                          input logic [9:0] ams, input logic [7:0] hdl,
                                          input logic [15:0] cid, input logic [31:0] ns,
                                          input logic [14:0] ps);
    alarm_req_t q;
    q.command = c; q.alarm_seconds = as_v; q.alarm_ms = ams; q.callback_handle = hdl;
    q.cancel_id = cid; q.now_seconds = ns; q.now_prescaler = ps;
    return q;
  endfunction

  initial begin
    logic [31:0] now_s;
    alarm_req_t  q;
    int unsigned pick;
    cycles = 0;
    calm = 1'b0;
    errors = 0;
    last_id = '0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    res_ch.ready = 1'b0;

    // Directed: empty queue, past, bump, wraps, odd ms, filling past full, no-op, cancels, fires.
    pending_reqs.push_back(make_req(CMD_FIRE, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(CMD_CANCEL, 0, 0, 0, 16'd5, 0, 0));
    pending_reqs.push_back(make_req(CMD_CANCEL, 0, 0, 0, 16'd0, 0, 0));
    pending_reqs.push_back(make_req(CMD_ADD, 32'd100, 10'd500, 8'hff, 0, 32'd100, 15'd16384));
    pending_reqs.push_back(make_req(CMD_ADD, 32'd100, 10'd501, 8'h01, 0, 32'd100, 15'd16384));
    pending_reqs.push_back(make_req(CMD_ADD, 32'hffffffff, 10'd1023, 8'h80, 0,
                                    32'hfffffffe, 15'h7fff));
    pending_reqs.push_back(make_req(CMD_ADD, 32'hffffffff, 10'd999, 8'h7f, 0,
                                    32'hffffffff, 15'd0));
    pending_reqs.push_back(make_req(CMD_NONE, 32'hffffffff, 10'h3ff, 8'hff, 16'hffff,
                                    32'hffffffff, 15'h7fff));
    for (int i = 0; i < 9; i++)
      pending_reqs.push_back(make_req(CMD_ADD, 32'd200 + i / 3, 10'(i * 7), 8'(i), 0,
                                      32'd50, 15'd0));
    pending_reqs.push_back(make_req(CMD_ADD, 32'd900, 10'd0, 8'h55, 0, 32'd50, 15'd0));
    pending_reqs.push_back(make_req(CMD_ADD, 32'd10, 10'd0, 8'h55, 0, 32'd50, 15'd0));
    pending_reqs.push_back(make_req(CMD_CANCEL, 0, 0, 0, 16'd4, 0, 0));
    pending_reqs.push_back(make_req(CMD_CANCEL, 0, 0, 0, 16'hffff, 0, 0));
    for (int i = 0; i < 5; i++) pending_reqs.push_back(make_req(CMD_FIRE, 0, 0, 0, 0, 0, 0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    now_s = $urandom();
    for (int n = 0; n < 460; n++) begin
      if (n == 230) begin
        // Hold the sender until the queue has drained every expected result.
        wait (pending_reqs.size() == 0 && !req_ch.valid && expected_res.size() == 0);
      end
      pick = $urandom_range(99);
      if ($urandom_range(49) == 0) now_s = $urandom();
      else now_s = now_s + $urandom_range(1);
      q = make_req(CMD_ADD, now_s + $urandom_range(4), 10'($urandom_range(1023)), 8'($urandom()),
                   16'($urandom()), now_s, 15'($urandom()));
      if (pick < 45) begin
        if ($urandom_range(9) == 0) q.alarm_seconds = $urandom();
      end else if (pick < 65) begin
        q.command = CMD_CANCEL;
        if (issued_ids.size() != 0 && $urandom_range(3) != 0)
          q.cancel_id = issued_ids[$urandom_range(issued_ids.size() - 1)];
      end else if (pick < 95) begin
        q.command = CMD_FIRE;
      end else begin
        q.command = CMD_NONE;
        n--;
      end
      pending_reqs.push_back(q);
    end

    wait (pending_reqs.size() == 0 && !req_ch.valid);
    wait (expected_res.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

FILE: sorted_alarm_queue.f
hdl/saq_pkg.sv
hdl/saq_if.sv
hdl/saq_cell.sv
hdl/sorted_alarm_queue.sv
verif/tb_top.sv
